// ===== src/ray_triangle_barycentric_interp_macros.svh =====
// Assertion helpers for the top RTL file of the ray/face test block.
// Both macros expect clk and rst_n in scope.
`ifndef RAY_TRIANGLE_BARYCENTRIC_INTERP_MACROS_SVH
`define RAY_TRIANGLE_BARYCENTRIC_INTERP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define RTBI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define RTBI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/rtbi_pkg.sv =====
`default_nettype none
package rtbi_pkg;

  // Coordinate width, Q16.16.
  localparam int CW = 32;
  // Edge and origin-offset width.
  localparam int EW = CW + 1;
  // Low slice width used to split the wide second-level products.
  localparam int LO = EW;
  // Width of all first-level products, cross terms and partial products.
  localparam int PPW = 2 * EW + 2;
  // Width of determinant and numerators.
  localparam int NW = 3 * CW + 6;
  // Fraction bits of a weight.
  localparam int W_FRAC = 16;
  // One integer step plus one step per fraction bit.
  localparam int DIV_STEPS = W_FRAC + 1;

  localparam int VERTEX_DEPTH_DEF = 16384;
  localparam int FACE_DEPTH_DEF = 32768;

  localparam logic [1:0] REQ_VERTEX = 2'd0;
  localparam logic [1:0] REQ_FACE = 2'd1;
  localparam logic [1:0] REQ_TEST = 2'd2;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAREST = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON = 1'd1;

  localparam logic [31:0] EPS_RESET = 32'd281474977;
  localparam logic [W_FRAC:0] ONE_Q16 = 17'h10000;

  typedef struct packed {
    logic [NW-1:0] den;
    logic [NW-1:0] nu;
    logic [NW-1:0] nv;
  } div_in_t;

endpackage
`default_nettype wire

// ===== src/ray_triangle_barycentric_interp.sv =====
`default_nettype none
// Channel   Direction  Handshake          Moves
// cfg_      in         cfg_we             register index and write data
// in_       in         in_valid/in_ready  vertex load, face load or ray test
// out_      out        out_valid/out_ready hit flag, weights, overlay value
//
// Loads are written at their transfer and produce no result.
// A ray test passes 30 register stages, and one item may enter every cycle
// while the output is not stalled. Most of these stages belong to the
// 17-stage weight fraction unit and the split low/high multiplier stages of
// the determinant datapath.
// Each stage holds while its successor is full and stalled, so bubbles
// collapse and nothing is dropped or repeated. Reset clears valid bits and
// configuration only; the vertex and face stores are not cleared.
module ray_triangle_barycentric_interp #(
  parameter int VERTEX_DEPTH = rtbi_pkg::VERTEX_DEPTH_DEF,
  parameter int FACE_DEPTH   = rtbi_pkg::FACE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rtbi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                     cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_req_type,
  input  logic [14:0]                     in_index,
  input  logic signed [31:0]              in_coord_x,
  input  logic signed [31:0]              in_coord_y,
  input  logic signed [31:0]              in_coord_z,
  input  logic signed [31:0]              in_overlay_in,
  input  logic [13:0]                     in_corner_a,
  input  logic [13:0]                     in_corner_b,
  input  logic [13:0]                     in_corner_c,
  input  logic                            in_want_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_hit,
  output logic signed [31:0]              out_interp_value,
  output logic [16:0]                     out_weight_l,
  output logic [16:0]                     out_weight_u,
  output logic [16:0]                     out_weight_v
);
  import rtbi_pkg::*;
  `include "ray_triangle_barycentric_interp_macros.svh"

  localparam int VAW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
  localparam int FAW = (FACE_DEPTH > 1) ? $clog2(FACE_DEPTH) : 1;
  localparam int VWW = 3 * CW + 32;
  localparam int FWW = 42;
  localparam int ST_DIV0 = 12;
  localparam int ST_MUL = ST_DIV0 + DIV_STEPS;
  localparam int NS = ST_MUL + 1;
  localparam int BPW = 32 + W_FRAC + 2;
  localparam int ACW = BPW + 2;

  localparam logic [1:0] PICK_L = 2'd0;
  localparam logic [1:0] PICK_U = 2'd1;
  localparam logic [1:0] PICK_V = 2'd2;

  // Configuration.
  logic        nearest_r;
  logic [31:0] det_eps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nearest_r <= 1'b0;
      det_eps_r <= EPS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NEAREST: nearest_r <= cfg_wdata[0];
        CFG_EPSILON: det_eps_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage valids and load enables.
  logic [NS:1]   vld_r;
  logic [NS+1:1] en;
  logic          in_fire, test_fire;

  always_comb begin
    en[NS+1] = out_ready;
    for (int k = NS; k >= 1; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_ready  = en[1];
  assign in_fire   = in_valid && in_ready;
  assign test_fire = in_fire && (in_req_type == REQ_TEST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[1]) begin
        vld_r[1] <= test_fire;
      end
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // Face store, read at the test's transfer.
  logic [FWW-1:0] face_mem [FACE_DEPTH];
  logic [FWW-1:0] face_q_r;
  logic           face_we;

  assign face_we = in_fire && (in_req_type == REQ_FACE) && (int'(in_index) < FACE_DEPTH);

  always_ff @(posedge clk) begin
    if (face_we) begin
      face_mem[FAW'(in_index)] <= {in_corner_c, in_corner_b, in_corner_a};
    end
    if (en[1]) begin
      face_q_r <= face_mem[FAW'(in_index)];
    end
  end

  // Stage 1 side data.
  logic signed [CW-1:0] s1_ray_r [3];
  logic                 s1_want_r, s1_ok_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_ray_r[0] <= in_coord_x;
      s1_ray_r[1] <= in_coord_y;
      s1_ray_r[2] <= in_coord_z;
      s1_want_r   <= in_want_value;
      s1_ok_r     <= int'(in_index) < FACE_DEPTH;
    end
  end

  // Vertex store, one copy per corner so all three read in the same cycle.
  logic [13:0]    corner [3];
  logic [VWW-1:0] vq_r [3];
  logic           vtx_we;

  assign corner[0] = face_q_r[13:0];
  assign corner[1] = face_q_r[27:14];
  assign corner[2] = face_q_r[41:28];
  assign vtx_we = in_fire && (in_req_type == REQ_VERTEX) && (int'(in_index) < VERTEX_DEPTH);

  genvar g;
  generate
    for (g = 0; g < 3; g++) begin : g_vcopy
      logic [VWW-1:0] vmem [VERTEX_DEPTH];
      always_ff @(posedge clk) begin
        if (vtx_we) begin
          vmem[VAW'(in_index)] <= {in_overlay_in, in_coord_z, in_coord_y, in_coord_x};
        end
        if (en[2]) begin
          vq_r[g] <= vmem[VAW'(corner[g])];
        end
      end
    end
  endgenerate

  logic signed [CW-1:0] s2_ray_r [3];
  logic                 s2_want_r, s2_ok_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_ray_r  <= s1_ray_r;
      s2_want_r <= s1_want_r;
      s2_ok_r   <= s1_ok_r && (int'(corner[0]) < VERTEX_DEPTH)
                   && (int'(corner[1]) < VERTEX_DEPTH) && (int'(corner[2]) < VERTEX_DEPTH);
    end
  end

  // Stage 3: edges and origin offset.
  logic signed [EW-1:0] s3_e1_r [3];
  logic signed [EW-1:0] s3_e2_r [3];
  logic signed [EW-1:0] s3_s_r  [3];
  logic signed [CW-1:0] s3_ray_r [3];
  logic signed [31:0]   s3_ov_r [3];
  logic                 s3_want_r, s3_ok_r;
  logic signed [CW-1:0] p0 [3];
  logic signed [CW-1:0] p1 [3];
  logic signed [CW-1:0] p2 [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p0[k] = vq_r[0][k*CW +: CW];
      p1[k] = vq_r[1][k*CW +: CW];
      p2[k] = vq_r[2][k*CW +: CW];
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int k = 0; k < 3; k++) begin
        s3_e1_r[k] <= EW'(p1[k]) - EW'(p0[k]);
        s3_e2_r[k] <= EW'(p2[k]) - EW'(p0[k]);
        s3_s_r[k]  <= -EW'(p0[k]);
        s3_ov_r[k] <= vq_r[k][3*CW +: 32];
      end
      s3_ray_r  <= s2_ray_r;
      s3_want_r <= s2_want_r;
      s3_ok_r   <= s2_ok_r;
    end
  end

  // Stage 4: cross-product terms.
  logic signed [PPW-1:0] s4_re_r [6];
  logic signed [PPW-1:0] s4_se_r [6];
  logic signed [EW-1:0]  s4_e1_r [3];
  logic signed [EW-1:0]  s4_s_r  [3];
  logic signed [CW-1:0]  s4_ray_r [3];
  logic signed [31:0]    s4_ov_r [3];
  logic                  s4_want_r, s4_ok_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_re_r[0] <= s3_ray_r[1] * s3_e2_r[2];
      s4_re_r[1] <= s3_ray_r[2] * s3_e2_r[1];
      s4_re_r[2] <= s3_ray_r[2] * s3_e2_r[0];
      s4_re_r[3] <= s3_ray_r[0] * s3_e2_r[2];
      s4_re_r[4] <= s3_ray_r[0] * s3_e2_r[1];
      s4_re_r[5] <= s3_ray_r[1] * s3_e2_r[0];
      s4_se_r[0] <= s3_s_r[1] * s3_e1_r[2];
      s4_se_r[1] <= s3_s_r[2] * s3_e1_r[1];
      s4_se_r[2] <= s3_s_r[2] * s3_e1_r[0];
      s4_se_r[3] <= s3_s_r[0] * s3_e1_r[2];
      s4_se_r[4] <= s3_s_r[0] * s3_e1_r[1];
      s4_se_r[5] <= s3_s_r[1] * s3_e1_r[0];
      s4_e1_r    <= s3_e1_r;
      s4_s_r     <= s3_s_r;
      s4_ray_r   <= s3_ray_r;
      s4_ov_r    <= s3_ov_r;
      s4_want_r  <= s3_want_r;
      s4_ok_r    <= s3_ok_r;
    end
  end

  // Stage 5: cross products h = ray x e2 and q = s x e1.
  logic signed [PPW-1:0] s5_h_r [3];
  logic signed [PPW-1:0] s5_q_r [3];
  logic signed [EW-1:0]  s5_e1_r [3];
  logic signed [EW-1:0]  s5_s_r  [3];
  logic signed [CW-1:0]  s5_ray_r [3];
  logic signed [31:0]    s5_ov_r [3];
  logic                  s5_want_r, s5_ok_r;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int k = 0; k < 3; k++) begin
        s5_h_r[k] <= s4_re_r[2*k] - s4_re_r[2*k+1];
        s5_q_r[k] <= s4_se_r[2*k] - s4_se_r[2*k+1];
      end
      s5_e1_r   <= s4_e1_r;
      s5_s_r    <= s4_s_r;
      s5_ray_r  <= s4_ray_r;
      s5_ov_r   <= s4_ov_r;
      s5_want_r <= s4_want_r;
      s5_ok_r   <= s4_ok_r;
    end
  end

  // Stage 6: dot products split into low and high partial products.
  // Terms 0-2 build the determinant, 3-5 the u numerator, 6-8 the v one.
  logic signed [PPW-1:0] s6_lo_r [9];
  logic signed [PPW-1:0] s6_hi_r [9];
  logic signed [31:0]    s6_ov_r [3];
  logic                  s6_want_r, s6_ok_r;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int k = 0; k < 3; k++) begin
        s6_lo_r[k]   <= s5_e1_r[k] * $signed({1'b0, s5_h_r[k][LO-1:0]});
        s6_hi_r[k]   <= s5_e1_r[k] * $signed(s5_h_r[k][PPW-1:LO]);
        s6_lo_r[3+k] <= s5_s_r[k] * $signed({1'b0, s5_h_r[k][LO-1:0]});
        s6_hi_r[3+k] <= s5_s_r[k] * $signed(s5_h_r[k][PPW-1:LO]);
        s6_lo_r[6+k] <= s5_ray_r[k] * $signed({1'b0, s5_q_r[k][LO-1:0]});
        s6_hi_r[6+k] <= s5_ray_r[k] * $signed(s5_q_r[k][PPW-1:LO]);
      end
      s6_ov_r   <= s5_ov_r;
      s6_want_r <= s5_want_r;
      s6_ok_r   <= s5_ok_r;
    end
  end

  // Stage 7: recombine the partial products.
  logic signed [NW-1:0] s7_c_r [9];
  logic signed [31:0]   s7_ov_r [3];
  logic                 s7_want_r, s7_ok_r;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      for (int m = 0; m < 9; m++) begin
        s7_c_r[m] <= (NW'(s6_hi_r[m]) <<< LO) + NW'(s6_lo_r[m]);
      end
      s7_ov_r   <= s6_ov_r;
      s7_want_r <= s6_want_r;
      s7_ok_r   <= s6_ok_r;
    end
  end

  // Stage 8: sums.
  logic signed [NW-1:0] s8_det_r, s8_nu_r, s8_nv_r;
  logic signed [31:0]   s8_ov_r [3];
  logic                 s8_want_r, s8_ok_r;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_det_r  <= s7_c_r[0] + s7_c_r[1] + s7_c_r[2];
      s8_nu_r   <= s7_c_r[3] + s7_c_r[4] + s7_c_r[5];
      s8_nv_r   <= s7_c_r[6] + s7_c_r[7] + s7_c_r[8];
      s8_ov_r   <= s7_ov_r;
      s8_want_r <= s7_want_r;
      s8_ok_r   <= s7_ok_r;
    end
  end

  // Stage 9: make the determinant nonnegative.
  logic signed [NW-1:0] s9_det_r, s9_nu_r, s9_nv_r;
  logic signed [31:0]   s9_ov_r [3];
  logic                 s9_want_r, s9_ok_r;

  always_ff @(posedge clk) begin
    if (en[9]) begin
      s9_det_r  <= s8_det_r[NW-1] ? -s8_det_r : s8_det_r;
      s9_nu_r   <= s8_det_r[NW-1] ? -s8_nu_r : s8_nu_r;
      s9_nv_r   <= s8_det_r[NW-1] ? -s8_nv_r : s8_nv_r;
      s9_ov_r   <= s8_ov_r;
      s9_want_r <= s8_want_r;
      s9_ok_r   <= s8_ok_r;
    end
  end

  // Stage 10: hit rule and corner-l numerator.
  logic signed [NW:0]   uv_sum;
  logic                 hit_c;
  logic signed [NW-1:0] s10_det_r, s10_nu_r, s10_nv_r, s10_wl_r;
  logic signed [31:0]   s10_ov_r [3];
  logic                 s10_want_r, s10_hit_r;

  always_comb begin
    uv_sum = (NW+1)'(s9_nu_r) + (NW+1)'(s9_nv_r);
    hit_c  = s9_ok_r && (s9_det_r != '0) && (s9_det_r >= $signed(NW'(det_eps_r)))
             && !s9_nu_r[NW-1] && (s9_nu_r <= s9_det_r)
             && !s9_nv_r[NW-1] && (uv_sum <= (NW+1)'(s9_det_r));
  end

  always_ff @(posedge clk) begin
    if (en[10]) begin
      s10_det_r  <= s9_det_r;
      s10_nu_r   <= s9_nu_r;
      s10_nv_r   <= s9_nv_r;
      s10_wl_r   <= NW'((NW+1)'(s9_det_r) - uv_sum);
      s10_ov_r   <= s9_ov_r;
      s10_want_r <= s9_want_r;
      s10_hit_r  <= hit_c;
    end
  end

  // Stage 11: nearest corner, first of l, u, v on ties.
  logic signed [NW-1:0] best;
  logic                 u_over_l;
  logic [1:0]           pick_c;
  logic signed [NW-1:0] s11_det_r, s11_nu_r, s11_nv_r;
  logic signed [31:0]   s11_ov_r [3];
  logic                 s11_want_r, s11_hit_r;
  logic [1:0]           s11_pick_r;

  always_comb begin
    u_over_l = s10_wl_r < s10_nu_r;
    best     = u_over_l ? s10_nu_r : s10_wl_r;
    if (best < s10_nv_r) begin
      pick_c = PICK_V;
    end else if (u_over_l) begin
      pick_c = PICK_U;
    end else begin
      pick_c = PICK_L;
    end
  end

  always_ff @(posedge clk) begin
    if (en[11]) begin
      s11_det_r  <= s10_det_r;
      s11_nu_r   <= s10_nu_r;
      s11_nv_r   <= s10_nv_r;
      s11_ov_r   <= s10_ov_r;
      s11_want_r <= s10_want_r;
      s11_hit_r  <= s10_hit_r;
      s11_pick_r <= pick_c;
    end
  end

  // Stages 12 to 28: weight fractions, side data alongside.
  div_in_t         div_in;
  logic [W_FRAC:0] wu_q, wv_q;

  assign div_in = '{den: s11_det_r, nu: s11_nu_r, nv: s11_nv_r};

  rtbi_frac u_frac (
    .clk (clk),
    .en  (en[ST_DIV0 +: DIV_STEPS]),
    .din (div_in),
    .wu  (wu_q),
    .wv  (wv_q)
  );

  logic signed [31:0] d_ov_r [DIV_STEPS][3];
  logic               d_want_r [DIV_STEPS];
  logic               d_hit_r [DIV_STEPS];
  logic [1:0]         d_pick_r [DIV_STEPS];

  generate
    for (g = 0; g < DIV_STEPS; g++) begin : g_side
      if (g == 0) begin : g_first
        always_ff @(posedge clk) begin
          if (en[ST_DIV0]) begin
            d_ov_r[0]   <= s11_ov_r;
            d_want_r[0] <= s11_want_r;
            d_hit_r[0]  <= s11_hit_r;
            d_pick_r[0] <= s11_pick_r;
          end
        end
      end else begin : g_rest
        always_ff @(posedge clk) begin
          if (en[ST_DIV0+g]) begin
            d_ov_r[g]   <= d_ov_r[g-1];
            d_want_r[g] <= d_want_r[g-1];
            d_hit_r[g]  <= d_hit_r[g-1];
            d_pick_r[g] <= d_pick_r[g-1];
          end
        end
      end
    end
  endgenerate

  // Stage 29: corner-l weight and blend products.
  logic [W_FRAC:0]       wl_c;
  logic signed [BPW-1:0] m_bp_r [3];
  logic [W_FRAC:0]       m_wl_r, m_wu_r, m_wv_r;
  logic signed [31:0]    m_near_r;
  logic                  m_want_r, m_hit_r;

  assign wl_c = ONE_Q16 - wu_q - wv_q;

  always_ff @(posedge clk) begin
    if (en[ST_MUL]) begin
      m_bp_r[0] <= d_ov_r[DIV_STEPS-1][0] * $signed({1'b0, wl_c});
      m_bp_r[1] <= d_ov_r[DIV_STEPS-1][1] * $signed({1'b0, wu_q});
      m_bp_r[2] <= d_ov_r[DIV_STEPS-1][2] * $signed({1'b0, wv_q});
      m_wl_r    <= wl_c;
      m_wu_r    <= wu_q;
      m_wv_r    <= wv_q;
      m_near_r  <= d_ov_r[DIV_STEPS-1][d_pick_r[DIV_STEPS-1]];
      m_want_r  <= d_want_r[DIV_STEPS-1];
      m_hit_r   <= d_hit_r[DIV_STEPS-1];
    end
  end

  // Stage 30: rounded blend and output register.
  logic signed [ACW-1:0] acc;
  logic signed [31:0]    val_c;
  logic                  out_hit_r;
  logic signed [31:0]    out_val_r;
  logic [W_FRAC:0]       out_wl_r, out_wu_r, out_wv_r;

  always_comb begin
    acc = ACW'(m_bp_r[0]) + ACW'(m_bp_r[1]) + ACW'(m_bp_r[2]) + ACW'(ONE_Q16 >> 1);
    if (!m_hit_r || !m_want_r) begin
      val_c = '0;
    end else if (nearest_r) begin
      val_c = m_near_r;
    end else begin
      // Arithmetic shift floors toward minus infinity.
      val_c = acc[W_FRAC +: 32];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS]) begin
      out_hit_r <= m_hit_r;
      out_val_r <= val_c;
      out_wl_r  <= m_hit_r ? m_wl_r : '0;
      out_wu_r  <= m_hit_r ? m_wu_r : '0;
      out_wv_r  <= m_hit_r ? m_wv_r : '0;
    end
  end

  assign out_valid        = vld_r[NS];
  assign out_hit          = out_hit_r;
  assign out_interp_value = out_val_r;
  assign out_weight_l     = out_wl_r;
  assign out_weight_u     = out_wu_r;
  assign out_weight_v     = out_wv_r;

  `RTBI_ASSERT_NXT(a_test_enters, test_fire, vld_r[1], "accepted test did not enter pipeline")
  `RTBI_ASSERT_IMP(a_empty_out_ready, !out_valid, in_ready, "input blocked with empty output")
  `RTBI_ASSERT_IMP(a_miss_zero, out_valid && !out_hit, (out_weight_l == '0) && (out_weight_u == '0) && (out_weight_v == '0) && (out_interp_value == '0), "miss result not zero")
  `RTBI_ASSERT_IMP(a_weight_sum, out_valid && out_hit, (19'(out_weight_l) + 19'(out_weight_u) + 19'(out_weight_v)) == 19'(ONE_Q16), "hit weights do not sum to one")

endmodule
`default_nettype wire

// ===== src/rtbi_frac.sv =====
`default_nettype none
// Restoring fraction pipeline: floor(num * 2^16 / den) for two numerators
// sharing one denominator, one compare-and-subtract per stage.
module rtbi_frac (
  input  logic                              clk,
  input  logic [rtbi_pkg::DIV_STEPS-1:0]    en,
  input  rtbi_pkg::div_in_t                 din,
  output logic [rtbi_pkg::W_FRAC:0]         wu,
  output logic [rtbi_pkg::W_FRAC:0]         wv
);
  import rtbi_pkg::*;

  logic [NW:0]     nu_r  [DIV_STEPS];
  logic [NW:0]     nv_r  [DIV_STEPS];
  logic [NW-1:0]   den_r [DIV_STEPS];
  logic [W_FRAC:0] qu_r  [DIV_STEPS];
  logic [W_FRAC:0] qv_r  [DIV_STEPS];

  genvar s;
  generate
    for (s = 0; s < DIV_STEPS; s++) begin : g_step
      logic [NW:0]     tu, tv, nu_nxt, nv_nxt;
      logic [NW-1:0]   den_c;
      logic [W_FRAC:0] qu_c, qv_c;
      logic            bu, bv;

      if (s == 0) begin : g_first
        always_comb begin
          tu    = {1'b0, din.nu};
          tv    = {1'b0, din.nv};
          den_c = din.den;
          qu_c  = '0;
          qv_c  = '0;
        end
      end else begin : g_rest
        // For a hit the numerator is at most the denominator, so the remainder stays below it and doubling fits.
        always_comb begin
          tu    = {nu_r[s-1][NW-1:0], 1'b0};
          tv    = {nv_r[s-1][NW-1:0], 1'b0};
          den_c = den_r[s-1];
          qu_c  = qu_r[s-1];
          qv_c  = qv_r[s-1];
        end
      end

      always_comb begin
        bu     = tu >= {1'b0, den_c};
        bv     = tv >= {1'b0, den_c};
        nu_nxt = bu ? tu - {1'b0, den_c} : tu;
        nv_nxt = bv ? tv - {1'b0, den_c} : tv;
      end

      always_ff @(posedge clk) begin
        if (en[s]) begin
          nu_r[s]  <= nu_nxt;
          nv_r[s]  <= nv_nxt;
          den_r[s] <= den_c;
          qu_r[s]  <= {qu_c[W_FRAC-1:0], bu};
          qv_r[s]  <= {qv_c[W_FRAC-1:0], bv};
        end
      end
    end
  endgenerate

  assign wu = qu_r[DIV_STEPS-1];
  assign wv = qv_r[DIV_STEPS-1];

endmodule
`default_nettype wire

// ===== test/ray_hit_checker.sv =====
`timescale 1ns / 100ps
module ray_hit_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rtbi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [1:0]                     in_req_type,
  input  logic [14:0]                    in_index,
  input  logic signed [31:0]             in_coord_x,
  input  logic signed [31:0]             in_coord_y,
  input  logic signed [31:0]             in_coord_z,
  input  logic signed [31:0]             in_overlay_in,
  input  logic [13:0]                    in_corner_a,
  input  logic [13:0]                    in_corner_b,
  input  logic [13:0]                    in_corner_c,
  input  logic                           in_want_value,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           out_hit,
  input  logic signed [31:0]             out_interp_value,
  input  logic [16:0]                    out_weight_l,
  input  logic [16:0]                    out_weight_u,
  input  logic [16:0]                    out_weight_v,
  output int                             errors,
  output int                             pending,
  output int                             n_results,
  output int                             n_hits
);
  import rtbi_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic              hit;
    logic signed [31:0] value;
    logic [16:0]       wl;
    logic [16:0]       wu;
    logic [16:0]       wv;
  } ray_result_t;

  logic signed [31:0] pos_x [VERTEX_DEPTH_DEF];
  logic signed [31:0] pos_y [VERTEX_DEPTH_DEF];
  logic signed [31:0] pos_z [VERTEX_DEPTH_DEF];
  logic signed [31:0] overlay [VERTEX_DEPTH_DEF];
  logic [13:0] face_corner [FACE_DEPTH_DEF][3];
  logic nearest;
  logic [31:0] epsilon;
  ray_result_t expected_hits [$];

  function automatic ray_result_t predict_hit(input int fidx, input logic signed [31:0] rx,
                                              input logic signed [31:0] ry,
                                              input logic signed [31:0] rz,
                                              input logic want);
    ray_result_t res;
    int c [3];
    wide_t p0 [3], p1 [3], p2 [3], r [3], e1 [3], e2 [3], s [3];
    wide_t h0, h1, h2, q0, q1, q2, det, nu, nv, wl, eps_w, best;
    longint acc;
    int pick;
    int wu16, wv16, wl16;
    res = '{hit: 1'b0, value: '0, wl: '0, wu: '0, wv: '0};
    for (int k = 0; k < 3; k++) c[k] = face_corner[fidx][k];
    p0[0] = pos_x[c[0]]; p0[1] = pos_y[c[0]]; p0[2] = pos_z[c[0]];
    p1[0] = pos_x[c[1]]; p1[1] = pos_y[c[1]]; p1[2] = pos_z[c[1]];
    p2[0] = pos_x[c[2]]; p2[1] = pos_y[c[2]]; p2[2] = pos_z[c[2]];
    r[0] = rx; r[1] = ry; r[2] = rz;
    for (int k = 0; k < 3; k++) begin
      e1[k] = p1[k] - p0[k];
      e2[k] = p2[k] - p0[k];
      s[k] = -p0[k];
    end
    h0 = r[1] * e2[2] - r[2] * e2[1];
    h1 = r[2] * e2[0] - r[0] * e2[2];
    h2 = r[0] * e2[1] - r[1] * e2[0];
    det = e1[0] * h0 + e1[1] * h1 + e1[2] * h2;
    nu = s[0] * h0 + s[1] * h1 + s[2] * h2;
    q0 = s[1] * e1[2] - s[2] * e1[1];
    q1 = s[2] * e1[0] - s[0] * e1[2];
    q2 = s[0] * e1[1] - s[1] * e1[0];
    nv = r[0] * q0 + r[1] * q1 + r[2] * q2;
    if (det < 0) begin
      det = -det;
      nu = -nu;
      nv = -nv;
    end
    eps_w = {96'd0, epsilon};
    if (det <= 0 || det < eps_w) return res;
    if (nu < 0 || nu > det) return res;
    if (nv < 0 || nu + nv > det) return res;
    wl = det - nu - nv;
    wu16 = int'((nu <<< 16) / det);
    wv16 = int'((nv <<< 16) / det);
    wl16 = 65536 - wu16 - wv16;
    res.hit = 1'b1;
    res.wl = wl16[16:0];
    res.wu = wu16[16:0];
    res.wv = wv16[16:0];
    if (want) begin
      if (nearest) begin
        // Ties go to the earlier corner.
        pick = 0;
        best = wl;
        if (best < nu) begin
          pick = 1;
          best = nu;
        end
        if (best < nv) pick = 2;
        res.value = overlay[c[pick]];
      end else begin
        acc = longint'(overlay[c[0]]) * wl16 + longint'(overlay[c[1]]) * wu16
              + longint'(overlay[c[2]]) * wv16 + 64'sd32768;
        acc = acc >>> 16;
        res.value = acc[31:0];
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint want_v, input longint got_v);
    $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, want_v, got_v);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
    n_results = 0;
    n_hits = 0;
  end

  always @(posedge clk) begin
    ray_result_t want_r;
    if (!rst_n) begin
      nearest <= 1'b0;
      epsilon <= EPS_RESET;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_NEAREST) nearest <= cfg_wdata[0];
        else if (cfg_index == CFG_EPSILON) epsilon <= cfg_wdata;
      end
      if (out_valid && out_ready) begin
        n_results++;
        if (out_hit) n_hits++;
        if (expected_hits.size() == 0) begin
          report_mismatch("unexpected result transfer", 0, 1);
        end else begin
          want_r = expected_hits.pop_front();
          if (out_hit !== want_r.hit) report_mismatch("hit", want_r.hit, out_hit);
          if (out_interp_value !== want_r.value)
            report_mismatch("interp_value", want_r.value, out_interp_value);
          if (out_weight_l !== want_r.wl) report_mismatch("weight_l", want_r.wl, out_weight_l);
          if (out_weight_u !== want_r.wu) report_mismatch("weight_u", want_r.wu, out_weight_u);
          if (out_weight_v !== want_r.wv) report_mismatch("weight_v", want_r.wv, out_weight_v);
        end
      end
      if (in_valid && in_ready) begin
        case (in_req_type)
          REQ_VERTEX: begin
            if (in_index < VERTEX_DEPTH_DEF) begin
              pos_x[in_index] = in_coord_x;
              pos_y[in_index] = in_coord_y;
              pos_z[in_index] = in_coord_z;
              overlay[in_index] = in_overlay_in;
            end
          end
          REQ_FACE: begin
            face_corner[in_index][0] = in_corner_a;
            face_corner[in_index][1] = in_corner_b;
            face_corner[in_index][2] = in_corner_c;
          end
          REQ_TEST: begin
            expected_hits.push_back(predict_hit(in_index, in_coord_x, in_coord_y, in_coord_z,
                                                in_want_value));
          end
          default: ;
        endcase
      end
    end
    pending = expected_hits.size();
  end
endmodule

// ===== test/ray_triangle_barycentric_interp_test.sv =====
`timescale 1ns / 100ps
module ray_triangle_barycentric_interp_test;
  import rtbi_pkg::*;

  typedef struct {
    logic [1:0]         kind;
    logic [14:0]        index;
    logic signed [31:0] x, y, z, ov;
    logic [13:0]        ca, cb, cc;
    logic               want;
  } item_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_wdata;
  logic in_valid, in_ready;
  logic [1:0] in_req_type;
  logic [14:0] in_index;
  logic signed [31:0] in_coord_x, in_coord_y, in_coord_z, in_overlay_in;
  logic [13:0] in_corner_a, in_corner_b, in_corner_c;
  logic in_want_value;
  logic out_valid, out_ready, out_hit;
  logic signed [31:0] out_interp_value;
  logic [16:0] out_weight_l, out_weight_u, out_weight_v;
  int errors, pending, n_results, n_hits;
  bit calm;

  // Stimulus-side copy of loaded geometry, used to aim rays at faces.
  int pos [VERTEX_DEPTH_DEF][3];
  bit vertex_seen [VERTEX_DEPTH_DEF];
  bit face_seen [FACE_DEPTH_DEF];
  int face_corner [FACE_DEPTH_DEF][3];
  int loaded_vertices [$];
  int loaded_faces [$];

  ray_triangle_barycentric_interp u_top (.*);

  ray_hit_checker u_checker (.*);

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 15);
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send(input item_t it);
    if (!calm && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= it.kind;
    in_index <= it.index;
    in_coord_x <= it.x;
    in_coord_y <= it.y;
    in_coord_z <= it.z;
    in_overlay_in <= it.ov;
    in_corner_a <= it.ca;
    in_corner_b <= it.cb;
    in_corner_c <= it.cc;
    in_want_value <= it.want;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (it.kind == REQ_VERTEX && it.index < VERTEX_DEPTH_DEF) begin
      pos[it.index] = '{it.x, it.y, it.z};
      if (!vertex_seen[it.index]) loaded_vertices.push_back(it.index);
      vertex_seen[it.index] = 1'b1;
    end else if (it.kind == REQ_FACE) begin
      face_corner[it.index] = '{it.ca, it.cb, it.cc};
      if (!face_seen[it.index]) loaded_faces.push_back(it.index);
      face_seen[it.index] = 1'b1;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Settle the pipeline completely; loads give no result, so pad for latency.
  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic item_t blank(input logic [1:0] kind, input int idx);
    item_t it;
    it = '{kind: kind, index: idx[14:0], x: $urandom, y: $urandom, z: $urandom,
           ov: $urandom, ca: $urandom, cb: $urandom, cc: $urandom, want: $urandom};
    return it;
  endfunction

  function automatic int rand_coord();
    int k;
    k = $urandom_range(99);
    if (k < 12) return int'($urandom_range(2047)) - 1024;
    if (k < 82) return int'($urandom_range(32'h7FFFFF)) - 32'sh400000;
    return $urandom;
  endfunction

  function automatic item_t vertex_item(input int idx, input int x, input int y,
                                        input int z, input int ov);
    item_t it;
    it = blank(REQ_VERTEX, idx);
    it.x = x;
    it.y = y;
    it.z = z;
    it.ov = ov;
    return it;
  endfunction

  function automatic item_t face_item(input int idx, input int a, input int b, input int c);
    item_t it;
    it = blank(REQ_FACE, idx);
    it.ca = a;
    it.cb = b;
    it.cc = c;
    return it;
  endfunction

  function automatic item_t ray_item(input int f, input int x, input int y, input int z,
                                     input bit want);
    item_t it;
    it = blank(REQ_TEST, f);
    it.x = x;
    it.y = y;
    it.z = z;
    it.want = want;
    return it;
  endfunction

  // Mostly rays through a point inside the face.
  function automatic item_t random_ray();
    int f, wa, wb, wc;
    longint p [3];
    f = loaded_faces[$urandom_range(loaded_faces.size() - 1)];
    if ($urandom_range(99) < 25) return ray_item(f, $urandom, $urandom, $urandom, $urandom);
    wa = $urandom_range(256);
    wb = $urandom_range(256 - wa);
    wc = 256 - wa - wb;
    for (int k = 0; k < 3; k++)
      p[k] = (longint'(pos[face_corner[f][0]][k]) * wa + longint'(pos[face_corner[f][1]][k]) * wb
              + longint'(pos[face_corner[f][2]][k]) * wc) >>> 8;
    return ray_item(f, p[0], p[1], p[2], $urandom);
  endfunction

  function automatic item_t random_item();
    int k, idx, n;
    k = $urandom_range(99);
    n = loaded_vertices.size();
    if (k < 14) begin
      idx = ($urandom_range(99) < 90) ? $urandom_range(255) : $urandom_range(32767);
      return vertex_item(idx, rand_coord(), rand_coord(), rand_coord(), $urandom);
    end
    if (k < 24) begin
      idx = ($urandom_range(99) < 85) ? $urandom_range(511) : $urandom_range(32767);
      return face_item(idx, loaded_vertices[$urandom_range(n - 1)],
                       loaded_vertices[$urandom_range(n - 1)],
                       loaded_vertices[$urandom_range(n - 1)]);
    end
    if (k < 96) return random_ray();
    return blank(2'd3, $urandom_range(32767));
  endfunction

  logic [31:0] phase_eps [6];
  logic        phase_near [6];

  initial begin
    cfg_we = 1'b0;
    cfg_index = CFG_NEAREST;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_req_type = REQ_VERTEX;
    in_index = '0;
    in_coord_x = '0;
    in_coord_y = '0;
    in_coord_z = '0;
    in_overlay_in = '0;
    in_corner_a = '0;
    in_corner_b = '0;
    in_corner_c = '0;
    in_want_value = 1'b0;
    out_ready = 1'b0;
    calm = 1'b0;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part at reset configuration.
    send(vertex_item(0, 0, 0, 65536, 32'h7FFFFFFF));
    send(vertex_item(1, 65536, 0, 65536, 32'h80000000));
    send(vertex_item(2, 0, 65536, 65536, 12345));
    send(vertex_item(3, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0));
    send(vertex_item(4, 32'h80000000, 32'h7FFFFFFF, 0, -1));
    send(vertex_item(16383, -1, -1, -1, 32'h80000000));
    send(vertex_item(16384 + 5, 1, 2, 3, 4));
    send(vertex_item(32767, 7, 7, 7, 7));
    send(face_item(0, 0, 1, 2));
    send(face_item(1, 3, 4, 16383));
    send(face_item(2, 0, 0, 0));
    send(face_item(32767, 16383, 1, 2));
    send(ray_item(0, 16384, 16384, 65536, 1'b1));
    send(ray_item(0, 0, 0, 65536, 1'b1));
    send(ray_item(0, 65536, 0, 65536, 1'b1));
    send(ray_item(0, 21845, 21845, 65536, 1'b1));
    send(ray_item(0, 65536, 65536, 65536, 1'b1));
    send(ray_item(0, 16384, 16384, 65536, 1'b0));
    send(ray_item(1, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1'b1));
    send(ray_item(1, -1, -1, -1, 1'b1));
    send(ray_item(2, 1, 1, 1, 1'b1));
    send(ray_item(32767, 16384, 16384, 65536, 1'b1));
    send(blank(2'd3, 0));
    // The sender holds off here until every pending result has come back.
    drain();

    phase_near = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    phase_eps = '{EPS_RESET, 32'd0, 32'hFFFFFFFF, $urandom, $urandom_range(1 << 20),
                  $urandom_range(32'h3FFFFFFF)};
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_NEAREST, {31'd0, phase_near[ph]});
      write_reg(CFG_EPSILON, phase_eps[ph]);
      for (int i = 0; i < 290; i++) begin
        calm = (ph == 2 && i >= 60 && i < 200);
        send(random_item());
      end
      calm = 1'b0;
      drain();
    end

    $display("Covered %0d ray results (%0d hits) across six register settings,",
             n_results, n_hits);
    $display("with vertex and face loads, out-of-range loads and unused requests mixed in.");
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
